// ===== design/dns_nd_pkg.sv =====
// shared types and constants for the dns name decompressor
`default_nettype none

package dns_nd_pkg;

	// fixed field widths of the channels
	localparam int unsigned ACT_W    = 2;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned POS_W    = 9;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned CONS_W   = 10;
	localparam int unsigned NLEN_W   = 9;

	// compression pointer layout
	localparam int unsigned PTR_W     = 14;
	localparam int unsigned PTR_HI_W  = 6;
	localparam logic [7:0]  PTR_MARK  = 8'b1100_0000;
	localparam logic [7:0]  PTR_HIGH  = 8'b0011_1111;
	localparam logic [7:0]  DOT_CHAR  = 8'h2E;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_DECODE = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_PAST_END  = 3'd1,
		ST_NOT_BACK  = 3'd2,
		ST_TOO_LONG  = 3'd3,
		ST_FULL      = 3'd4,
		ST_BAD_INDEX = 3'd5
	} status_t;

endpackage

`default_nettype wire

// ===== design/dns_name_decompressor.sv =====
// dns name decompressor: message store, label walk sequencer and name store
//
// Input channel (in_valid/in_ready) carries one action per beat: clear the
// message, append a message byte, decode a name at an offset, or read one
// character of the last decoded name. Output channel (out_valid/out_ready)
// returns exactly one result beat per input beat, in order.
// The message and the name sit in synchronous memories with registered
// read data; a sequencer walks the message byte by byte.
// A decode passes through S_LEN_CHK and S_LEN for each length byte, S_PTR
// for a pointer's low byte and S_LABEL for each label character; read char
// passes through S_RD, and every action ends in S_DONE, which loads the
// output register.
// The message memory read port, one byte per cycle, sets the decode time.
// One beat is handled at a time; a new beat is taken as soon as the
// sequencer is idle, even while the previous result still waits in the
// output register. A stalled receiver holds the result and, once a second
// result is ready, holds the sequencer too.
// Reset empties the message and the name; no clearing pass is needed.
`default_nettype none

module dns_name_decompressor #(
	parameter int unsigned MSG_BYTES  = 512,
	parameter int unsigned NAME_BYTES = 256
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [dns_nd_pkg::ACT_W-1:0]       action,
	input  wire logic [dns_nd_pkg::BYTE_W-1:0]      byte_value,
	input  wire logic [dns_nd_pkg::POS_W-1:0]       position,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [dns_nd_pkg::STATUS_W-1:0]         status,
	output logic [dns_nd_pkg::CONS_W-1:0]           consumed_bytes,
	output logic [dns_nd_pkg::NLEN_W-1:0]           name_length,
	output logic [dns_nd_pkg::BYTE_W-1:0]           name_char
);

	localparam int unsigned AW  = $clog2(MSG_BYTES);
	localparam int unsigned LW  = $clog2(MSG_BYTES + 1);
	localparam int unsigned OW  = ((LW > dns_nd_pkg::PTR_W) ? LW : dns_nd_pkg::PTR_W) + 1;
	localparam int unsigned NAW = $clog2(NAME_BYTES);
	localparam int unsigned NW  = $clog2(NAME_BYTES + 1);
	localparam int unsigned PW  = (NW > dns_nd_pkg::POS_W) ? NW : dns_nd_pkg::POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEN_CHK,
		S_LEN,
		S_LABEL,
		S_PTR,
		S_RD,
		S_DONE
	} state_t;

	state_t                            state_q;
	logic [LW-1:0]                     msg_len_q;
	logic [NW-1:0]                     name_cnt_q;
	logic [OW-1:0]                     off_q;
	logic [OW-1:0]                     seg_q;
	logic [OW-1:0]                     used_q;
	logic [dns_nd_pkg::POS_W-1:0]      start_q;
	logic [NW-1:0]                     len_q;
	logic                              seg_lab_q;
	logic                              top_q;
	logic [7:0]                        cnt_q;
	logic [dns_nd_pkg::PTR_HI_W-1:0]   hi_q;
	dns_nd_pkg::status_t               res_status_q;
	logic [dns_nd_pkg::CONS_W-1:0]     res_cons_q;
	logic [dns_nd_pkg::NLEN_W-1:0]     res_len_q;
	logic [dns_nd_pkg::BYTE_W-1:0]     res_char_q;
	logic                              out_valid_q;
	dns_nd_pkg::status_t               status_q;
	logic [dns_nd_pkg::CONS_W-1:0]     consumed_q;
	logic [dns_nd_pkg::NLEN_W-1:0]     nlen_q;
	logic [dns_nd_pkg::BYTE_W-1:0]     char_q;

	// memories
	logic [7:0] msg_mem [MSG_BYTES];
	logic [7:0] name_mem [NAME_BYTES];
	logic [7:0] msg_rd_q;
	logic [7:0] name_rd_q;

	dns_nd_pkg::action_t act;
	logic                accept;
	logic                msg_we;
	logic [OW-1:0]       msg_len_x;
	logic                off_past;
	logic                lab_past;
	logic                is_ptr;
	logic                name_full;
	logic [OW-1:0]       target;
	logic [OW-1:0]       used_now;
	logic [PW-1:0]       pos_x;
	logic                rd_bad;
	logic                fail;
	dns_nd_pkg::status_t fail_code;
	logic                finish;
	logic                nm_we;
	logic [7:0]          nm_wdata;

	assign act      = dns_nd_pkg::action_t'(action);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign msg_we   = accept && (act == dns_nd_pkg::ACT_APPEND) &&
	                  (msg_len_q < LW'(MSG_BYTES));

	// walk helpers
	assign msg_len_x = OW'(msg_len_q);
	assign off_past  = (off_q >= msg_len_x);
	assign lab_past  = ((off_q + OW'(msg_rd_q)) > msg_len_x);
	assign is_ptr    = ((msg_rd_q & dns_nd_pkg::PTR_MARK) == dns_nd_pkg::PTR_MARK);
	assign name_full = (len_q >= NW'(NAME_BYTES));
	assign target    = OW'({hi_q, msg_rd_q});
	assign used_now  = off_q - OW'(start_q);
	assign pos_x     = PW'(position);
	assign rd_bad    = (pos_x >= PW'(name_cnt_q));

	// message memory: append port and walk read port
	always_ff @(posedge clk) begin
		if (msg_we) begin
			msg_mem[msg_len_q[AW-1:0]] <= byte_value;
		end
		msg_rd_q <= msg_mem[off_q[AW-1:0]];
	end

	// name memory: decode write port and char read port
	always_ff @(posedge clk) begin
		if (nm_we) begin
			name_mem[len_q[NAW-1:0]] <= nm_wdata;
		end
		name_rd_q <= name_mem[pos_x[NAW-1:0]];
	end

	// per-state checks and name writes
	always_comb begin
		fail      = 1'b0;
		fail_code = dns_nd_pkg::ST_OK;
		finish    = 1'b0;
		nm_we     = 1'b0;
		nm_wdata  = dns_nd_pkg::DOT_CHAR;
		case (state_q)
			S_LEN_CHK: begin
				if (off_past) begin
					fail      = 1'b1;
					fail_code = dns_nd_pkg::ST_PAST_END;
				end
			end
			S_LEN: begin
				if (msg_rd_q == 8'd0) begin
					finish = 1'b1;
				end else if (is_ptr) begin
					if (off_past) begin
						fail      = 1'b1;
						fail_code = dns_nd_pkg::ST_PAST_END;
					end
				end else if (lab_past) begin
					fail      = 1'b1;
					fail_code = dns_nd_pkg::ST_PAST_END;
				end else if (seg_lab_q) begin
					if (name_full) begin
						fail      = 1'b1;
						fail_code = dns_nd_pkg::ST_TOO_LONG;
					end else begin
						nm_we = 1'b1;
					end
				end
			end
			S_LABEL: begin
				if (name_full) begin
					fail      = 1'b1;
					fail_code = dns_nd_pkg::ST_TOO_LONG;
				end else begin
					nm_we    = 1'b1;
					nm_wdata = msg_rd_q;
				end
			end
			S_PTR: begin
				if (target >= seg_q) begin
					fail      = 1'b1;
					fail_code = dns_nd_pkg::ST_NOT_BACK;
				end else if (seg_lab_q) begin
					if (name_full) begin
						fail      = 1'b1;
						fail_code = dns_nd_pkg::ST_TOO_LONG;
					end else begin
						nm_we = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			msg_len_q    <= '0;
			name_cnt_q   <= '0;
			off_q        <= '0;
			seg_q        <= '0;
			used_q       <= '0;
			start_q      <= '0;
			len_q        <= '0;
			seg_lab_q    <= 1'b0;
			top_q        <= 1'b0;
			cnt_q        <= '0;
			hi_q         <= '0;
			res_status_q <= dns_nd_pkg::ST_OK;
			res_cons_q   <= '0;
			res_len_q    <= '0;
			res_char_q   <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= dns_nd_pkg::ST_OK;
			consumed_q   <= '0;
			nlen_q       <= '0;
			char_q       <= '0;
		end else begin
			// result beat taken while no new result is loaded
			if (out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (fail) begin
				res_status_q <= fail_code;
				res_cons_q   <= '0;
				res_len_q    <= '0;
				res_char_q   <= '0;
				name_cnt_q   <= '0;
				state_q      <= S_DONE;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (in_valid) begin
							res_cons_q <= '0;
							res_char_q <= '0;
							case (act)
								dns_nd_pkg::ACT_CLEAR: begin
									res_status_q <= dns_nd_pkg::ST_OK;
									res_len_q    <= '0;
									msg_len_q    <= '0;
									state_q      <= S_DONE;
								end
								dns_nd_pkg::ACT_APPEND: begin
									res_len_q <= '0;
									if (msg_we) begin
										msg_len_q    <= msg_len_q + 1'b1;
										res_status_q <= dns_nd_pkg::ST_OK;
									end else begin
										res_status_q <= dns_nd_pkg::ST_FULL;
									end
									state_q <= S_DONE;
								end
								dns_nd_pkg::ACT_DECODE: begin
									res_status_q <= dns_nd_pkg::ST_OK;
									res_len_q    <= '0;
									off_q        <= OW'(position);
									seg_q        <= OW'(position);
									start_q      <= position;
									used_q       <= '0;
									len_q        <= '0;
									seg_lab_q    <= 1'b0;
									top_q        <= 1'b1;
									state_q      <= S_LEN_CHK;
								end
								dns_nd_pkg::ACT_READ: begin
									res_len_q <= dns_nd_pkg::NLEN_W'(name_cnt_q);
									if (rd_bad) begin
										res_status_q <= dns_nd_pkg::ST_BAD_INDEX;
									end else begin
										res_status_q <= dns_nd_pkg::ST_OK;
									end
									state_q <= S_RD;
								end
								default: begin
									res_status_q <= dns_nd_pkg::ST_OK;
									res_len_q    <= '0;
									state_q      <= S_DONE;
								end
							endcase
						end
					end
					S_LEN_CHK: begin
						// length byte is being read
						off_q   <= off_q + 1'b1;
						state_q <= S_LEN;
					end
					S_LEN: begin
						if (finish) begin
							res_status_q <= dns_nd_pkg::ST_OK;
							res_cons_q   <= top_q ? dns_nd_pkg::CONS_W'(used_now)
							                      : dns_nd_pkg::CONS_W'(used_q);
							res_len_q    <= dns_nd_pkg::NLEN_W'(len_q);
							res_char_q   <= '0;
							name_cnt_q   <= len_q;
							state_q      <= S_DONE;
						end else if (is_ptr) begin
							hi_q    <= msg_rd_q[dns_nd_pkg::PTR_HI_W-1:0];
							off_q   <= off_q + 1'b1;
							state_q <= S_PTR;
						end else begin
							if (seg_lab_q) begin
								len_q <= len_q + 1'b1;
							end
							cnt_q   <= msg_rd_q;
							off_q   <= off_q + 1'b1;
							state_q <= S_LABEL;
						end
					end
					S_LABEL: begin
						// one label character per cycle
						len_q <= len_q + 1'b1;
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == 8'd1) begin
							state_q <= S_LEN_CHK;
						end else begin
							off_q <= off_q + 1'b1;
						end
					end
					S_PTR: begin
						if (top_q) begin
							used_q <= used_now;
						end
						top_q <= 1'b0;
						if (seg_lab_q) begin
							len_q <= len_q + 1'b1;
						end
						seg_lab_q <= 1'b0;
						seg_q     <= target;
						off_q     <= target;
						state_q   <= S_LEN_CHK;
					end
					S_RD: begin
						res_char_q <= (res_status_q == dns_nd_pkg::ST_OK) ? name_rd_q : '0;
						state_q    <= S_DONE;
					end
					S_DONE: begin
						if (!out_valid_q || out_ready) begin
							out_valid_q <= 1'b1;
							status_q    <= res_status_q;
							consumed_q  <= res_cons_q;
							nlen_q      <= res_len_q;
							char_q      <= res_char_q;
							state_q     <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
				// a finished label leaves a dot pending for the next label or pointer
				if (state_q == S_LABEL && cnt_q == 8'd1) begin
					seg_lab_q <= 1'b1;
				end
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign consumed_bytes = consumed_q;
	assign name_length    = nlen_q;
	assign name_char      = char_q;

	// checks
	a_msg_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		msg_len_q <= LW'(MSG_BYTES))
		else $error("message length beyond store size");

	a_name_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q <= NW'(NAME_BYTES)) && (name_cnt_q <= NW'(NAME_BYTES)))
		else $error("name length beyond store size");

	a_label_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LABEL) |-> (cnt_q != 8'd0))
		else $error("label copy with no characters left");

	a_ptr_backward: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PTR && !fail) |=> (seg_q < $past(seg_q)))
		else $error("pointer followed without moving backward");

	a_fail_no_consume: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != dns_nd_pkg::ST_OK) |-> (consumed_bytes == '0))
		else $error("failed beat reports consumed bytes");

endmodule

`default_nettype wire

// ===== verif/dns_nd_checker.sv =====
// checker for the dns name decompressor: mirrors both stores, predicts and compares result beats
`default_nettype none

module dns_nd_checker #(
	parameter int unsigned MSG_BYTES  = 512,
	parameter int unsigned NAME_BYTES = 256
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire logic                               in_ready,
	input  wire logic [dns_nd_pkg::ACT_W-1:0]       action,
	input  wire logic [dns_nd_pkg::BYTE_W-1:0]      byte_value,
	input  wire logic [dns_nd_pkg::POS_W-1:0]       position,
	input  wire logic                               out_valid,
	input  wire logic                               out_ready,
	input  wire logic [dns_nd_pkg::STATUS_W-1:0]    status,
	input  wire logic [dns_nd_pkg::CONS_W-1:0]      consumed_bytes,
	input  wire logic [dns_nd_pkg::NLEN_W-1:0]      name_length,
	input  wire logic [dns_nd_pkg::BYTE_W-1:0]      name_char,
	output int unsigned                             fail_count,
	output int unsigned                             open_count
);

	typedef struct {
		dns_nd_pkg::status_t             st;
		logic [dns_nd_pkg::CONS_W-1:0]   used;
		logic [dns_nd_pkg::NLEN_W-1:0]   nlen;
		logic [dns_nd_pkg::BYTE_W-1:0]   ch;
	} dns_result_t;

	// mirror of the block's stores
	logic [7:0]  msg_mirror [MSG_BYTES];
	logic [7:0]  name_mirror [NAME_BYTES];
	int unsigned msg_len;
	int unsigned name_len;

	dns_result_t results_due [$];

	// walk labels and pointers from start, building the dotted name in the mirror
	function automatic dns_nd_pkg::status_t walk_name(input int unsigned start,
			output int unsigned used);
		int unsigned         off;
		int unsigned         seg_start;
		int unsigned         len;
		int unsigned         k;
		logic [7:0]          lbyte;
		logic [15:0]         target;
		bit                  seg_has_label;
		bit                  top;
		bit                  fin;
		dns_nd_pkg::status_t st;
		off = start;
		seg_start = start;
		len = 0;
		seg_has_label = 1'b0;
		top = 1'b1;
		fin = 1'b0;
		st = dns_nd_pkg::ST_OK;
		used = 0;
		while (!fin) begin
			if (off >= msg_len) begin
				st = dns_nd_pkg::ST_PAST_END;
				fin = 1'b1;
			end else begin
				lbyte = msg_mirror[off];
				off++;
				if (lbyte == 8'h00) begin
					// terminator ends the name
					if (top)
						used = off - start;
					name_len = len;
					fin = 1'b1;
				end else if ((lbyte & dns_nd_pkg::PTR_MARK) == dns_nd_pkg::PTR_MARK) begin
					// compression pointer, only strictly backward of the segment start
					if (off >= msg_len) begin
						st = dns_nd_pkg::ST_PAST_END;
						fin = 1'b1;
					end else begin
						target = {lbyte & dns_nd_pkg::PTR_HIGH, msg_mirror[off]};
						off++;
						if (target >= seg_start) begin
							st = dns_nd_pkg::ST_NOT_BACK;
							fin = 1'b1;
						end else if (seg_has_label && len >= NAME_BYTES) begin
							st = dns_nd_pkg::ST_TOO_LONG;
							fin = 1'b1;
						end else begin
							if (top)
								used = off - start;
							top = 1'b0;
							if (seg_has_label) begin
								name_mirror[len] = dns_nd_pkg::DOT_CHAR;
								len++;
							end
							seg_has_label = 1'b0;
							seg_start = target;
							off = target;
						end
					end
				end else if (off + lbyte > msg_len) begin
					st = dns_nd_pkg::ST_PAST_END;
					fin = 1'b1;
				end else if (seg_has_label && len >= NAME_BYTES) begin
					st = dns_nd_pkg::ST_TOO_LONG;
					fin = 1'b1;
				end else begin
					// plain label, copied character by character
					if (seg_has_label) begin
						name_mirror[len] = dns_nd_pkg::DOT_CHAR;
						len++;
					end
					for (k = 0; k < lbyte && !fin; k++) begin
						if (len >= NAME_BYTES) begin
							st = dns_nd_pkg::ST_TOO_LONG;
							fin = 1'b1;
						end else begin
							name_mirror[len] = msg_mirror[off + k];
							len++;
						end
					end
					off += lbyte;
					seg_has_label = 1'b1;
				end
			end
		end
		return st;
	endfunction

	// apply one action beat to the mirror and work out its result
	function automatic dns_result_t apply_action(input dns_nd_pkg::action_t act,
			input logic [7:0] b, input logic [8:0] pos);
		dns_result_t r;
		int unsigned used;
		r.st = dns_nd_pkg::ST_OK;
		r.used = '0;
		r.nlen = '0;
		r.ch = '0;
		case (act)
			dns_nd_pkg::ACT_CLEAR: begin
				msg_len = 0;
			end
			dns_nd_pkg::ACT_APPEND: begin
				if (msg_len >= MSG_BYTES) begin
					r.st = dns_nd_pkg::ST_FULL;
				end else begin
					msg_mirror[msg_len] = b;
					msg_len++;
				end
			end
			dns_nd_pkg::ACT_DECODE: begin
				r.st = walk_name(pos, used);
				if (r.st == dns_nd_pkg::ST_OK) begin
					r.used = dns_nd_pkg::CONS_W'(used);
					r.nlen = dns_nd_pkg::NLEN_W'(name_len);
				end else begin
					name_len = 0;
				end
			end
			dns_nd_pkg::ACT_READ: begin
				r.nlen = dns_nd_pkg::NLEN_W'(name_len);
				if (pos >= name_len || pos >= NAME_BYTES)
					r.st = dns_nd_pkg::ST_BAD_INDEX;
				else
					r.ch = name_mirror[pos];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// compare result beats first, then record the new action beat
	always @(posedge clk or negedge arst_n) begin
		int unsigned bad;
		dns_result_t want;
		if (!arst_n) begin
			msg_len = 0;
			name_len = 0;
			results_due.delete();
			fail_count <= 0;
			open_count <= 0;
		end else begin
			bad = 0;
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("result beat with no action outstanding");
					bad++;
				end else begin
					want = results_due.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						bad++;
					end
					if (consumed_bytes !== want.used) begin
						$error("consumed_bytes: expected %0d, got %0d", want.used,
							consumed_bytes);
						bad++;
					end
					if (name_length !== want.nlen) begin
						$error("name_length: expected %0d, got %0d", want.nlen, name_length);
						bad++;
					end
					if (name_char !== want.ch) begin
						$error("name_char: expected %0d, got %0d", want.ch, name_char);
						bad++;
					end
				end
			end
			if (in_valid && in_ready)
				results_due.push_back(apply_action(dns_nd_pkg::action_t'(action),
					byte_value, position));
			fail_count <= fail_count + bad;
			open_count <= results_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// top of the dns name decompressor testbench: clock, reset, action beats and verdict
`default_nettype none

module tb;

	localparam int unsigned MSG_BYTES    = 512;
	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 60;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [dns_nd_pkg::ACT_W-1:0]    action = dns_nd_pkg::ACT_CLEAR;
	logic [dns_nd_pkg::BYTE_W-1:0]   byte_value = '0;
	logic [dns_nd_pkg::POS_W-1:0]    position = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [dns_nd_pkg::STATUS_W-1:0] status;
	logic [dns_nd_pkg::CONS_W-1:0]   consumed_bytes;
	logic [dns_nd_pkg::NLEN_W-1:0]   name_length;
	logic [dns_nd_pkg::BYTE_W-1:0]   name_char;

	int unsigned fail_count;
	int unsigned open_count;
	int unsigned cycles = 0;
	int unsigned snd_idle = 27;
	int unsigned rcv_idle = 87;
	int unsigned hold_asked = 0;
	int unsigned hold_taken = 0;
	int unsigned hold_left = 0;
	int unsigned sent = 0;

	// what the stimulus knows of the message being built
	int unsigned msg_fill = 0;
	int unsigned bounds [$];

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	dns_name_decompressor dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.byte_value     (byte_value),
		.position       (position),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.consumed_bytes (consumed_bytes),
		.name_length    (name_length),
		.name_char      (name_char)
	);

	dns_nd_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.byte_value     (byte_value),
		.position       (position),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.consumed_bytes (consumed_bytes),
		.name_length    (name_length),
		.name_char      (name_char),
		.fail_count     (fail_count),
		.open_count     (open_count)
	);

	// receiver: random stalls, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_taken != hold_asked) begin
			hold_taken <= hold_taken + 1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rcv_idle);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// offer one beat, with random gaps before it, and wait for acceptance
	task automatic send_beat(input dns_nd_pkg::action_t act, input logic [7:0] b,
			input logic [8:0] pos);
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		byte_value <= b;
		position <= pos;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		send_beat(dns_nd_pkg::ACT_APPEND, b, 9'($urandom_range(0, 511)));
		msg_fill++;
	endtask

	task automatic clear_msg();
		send_beat(dns_nd_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)),
			9'($urandom_range(0, 511)));
		msg_fill = 0;
		bounds.delete();
	endtask

	task automatic decode_at(input logic [8:0] pos);
		send_beat(dns_nd_pkg::ACT_DECODE, 8'($urandom_range(0, 255)), pos);
	endtask

	task automatic read_char(input logic [8:0] idx);
		send_beat(dns_nd_pkg::ACT_READ, 8'($urandom_range(0, 255)), idx);
	endtask

	// length byte followed by random characters
	task automatic put_label(input int unsigned len);
		bounds.push_back(msg_fill);
		push_byte(8'(len));
		repeat (len)
			push_byte(8'($urandom_range(0, 255)));
	endtask

	// one name: up to three labels, then a terminator or a pointer
	task automatic add_name();
		int unsigned first;
		int unsigned n_before;
		int unsigned roll;
		int unsigned len;
		logic [13:0] tgt;
		first = msg_fill;
		n_before = bounds.size();
		repeat ($urandom_range(0, 3)) begin
			roll = $urandom_range(0, 99);
			if (roll < 5 && msg_fill < 150)
				len = $urandom_range(64, 191);
			else if (roll < 20)
				len = $urandom_range(9, 63);
			else
				len = $urandom_range(1, 8);
			put_label(len);
		end
		roll = $urandom_range(0, 99);
		bounds.push_back(msg_fill);
		if (n_before > 0 && roll < 55) begin
			// backward pointer to an earlier recorded length, pointer or terminator byte
			tgt = 14'(bounds[$urandom_range(0, n_before - 1)]);
			push_byte(dns_nd_pkg::PTR_MARK | {2'b00, tgt[13:8]});
			push_byte(tgt[7:0]);
		end else if (roll < 63) begin
			// pointer at or beyond its own segment
			tgt = 14'($urandom_range(first, 16383));
			push_byte(dns_nd_pkg::PTR_MARK | {2'b00, tgt[13:8]});
			push_byte(tgt[7:0]);
		end else begin
			push_byte(8'h00);
		end
	endtask

	// build or extend a message, then decode at several offsets and read back
	task automatic random_round();
		int unsigned roll;
		int unsigned pos;
		if (msg_fill >= 300 || $urandom_range(0, 99) < 80)
			clear_msg();
		repeat ($urandom_range(0, 1))
			read_char(9'($urandom_range(0, 24)));
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 40))
				push_byte(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 4))
				if (msg_fill < 300)
					add_name();
		end
		repeat ($urandom_range(2, 6)) begin
			roll = $urandom_range(0, 99);
			if (roll < 75 && bounds.size() > 0)
				pos = bounds[$urandom_range(0, bounds.size() - 1)];
			else if (roll < 90)
				pos = $urandom_range(0, msg_fill + 2);
			else
				pos = $urandom_range(0, 511);
			decode_at(9'(pos));
			repeat ($urandom_range(0, 4)) begin
				if ($urandom_range(0, 99) < 70)
					read_char(9'($urandom_range(0, 24)));
				else
					read_char(9'($urandom_range(0, 511)));
			end
		end
	endtask

	task automatic random_phase(input int unsigned count);
		int unsigned goal;
		goal = sent + count;
		while (sent < goal)
			random_round();
	endtask

	// stimulus and verdict
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty name and empty message
		read_char(9'd0);
		decode_at(9'd0);
		// "w" at 0, "x" plus pointer at 3, bare pointer to a terminator at 7,
		// label then pointer to a terminator at 9, self pointer at 13,
		// pointer missing its low byte at 15
		push_byte(8'h01);
		push_byte("w");
		push_byte(8'h00);
		push_byte(8'h01);
		push_byte("x");
		push_byte(dns_nd_pkg::PTR_MARK);
		push_byte(8'h00);
		push_byte(dns_nd_pkg::PTR_MARK);
		push_byte(8'h02);
		push_byte(8'h01);
		push_byte("z");
		push_byte(dns_nd_pkg::PTR_MARK);
		push_byte(8'h02);
		push_byte(dns_nd_pkg::PTR_MARK);
		push_byte(8'h0D);
		push_byte(dns_nd_pkg::PTR_MARK | 8'h01);
		decode_at(9'd3);
		read_char(9'd1);
		read_char(9'd3);
		decode_at(9'd7);
		decode_at(9'd9);
		decode_at(9'd13);
		decode_at(9'd15);
		// 'w' taken as a label length runs past the end
		decode_at(9'd1);
		decode_at(9'd511);

		random_phase(30);
		snd_idle = 87;
		rcv_idle = 27;
		random_phase(30);
		snd_idle = 0;
		rcv_idle = 0;

		// long receiver hold-off while appends keep coming
		clear_msg();
		hold_asked <= hold_asked + 1;
		repeat (30)
			push_byte(8'($urandom_range(0, 255)));
		random_phase(30);

		// full-size names, name overflow on a dot and on a character, store full
		clear_msg();
		put_label(191);
		put_label(64);
		push_byte(8'h01);
		push_byte(8'($urandom_range(0, 255)));
		push_byte(8'h00);
		put_label(189);
		push_byte(dns_nd_pkg::PTR_MARK);
		push_byte(8'hC0);
		push_byte(8'h01);
		push_byte(8'($urandom_range(0, 255)));
		push_byte(dns_nd_pkg::PTR_MARK);
		push_byte(8'h00);
		while (msg_fill < MSG_BYTES + 2)
			push_byte(8'($urandom_range(0, 255)));
		decode_at(9'd0);
		decode_at(9'd192);
		decode_at(9'd260);
		read_char(9'd255);
		read_char(9'd256);
		decode_at(9'd452);
		read_char(9'd0);

		// drain
		in_valid <= 1'b0;
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && open_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
design/dns_nd_pkg.sv
design/dns_name_decompressor.sv
verif/dns_nd_checker.sv
verif/tb.sv
